>>> src/assert_macros.svh
// Concurrent assertion macros shared by the byte FIFO RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset
`define BBSF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbsf assertion failed");

// Next-cycle implication, sampled on clk and held off during reset
`define BBSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbsf assertion failed");

`endif

>>> src/bbsf_pkg.sv
// Shared types, constants and command codes for the bounded byte FIFO
`timescale 1ns / 1ps

package bbsf_pkg;

    // Storage geometry
    localparam int DEPTH   = 4096;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = $clog2(2 * DEPTH);

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int CAP_W   = 13;
    localparam int COUNT_W = 13;
    localparam int TOTAL_W = 32;

    // Comparison widths wide enough for both operands
    localparam int CAP_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int LEN_CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]   CAP_RESET    = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_CLOSE  = 3'd2,
        CMD_ERROR  = 3'd3,
        CMD_STATUS = 3'd4
    } cmd_e;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  pop_length;
    } cmd_item_t;

    typedef struct packed {
        logic               push_accepted;
        logic [BYTE_W-1:0]  head_byte;
        logic               head_valid;
        logic [COUNT_W-1:0] buffered_count;
        logic [COUNT_W-1:0] free_space;
        logic [TOTAL_W-1:0] pushed_sum;
        logic [TOTAL_W-1:0] total_popped;
        logic               closed_flag;
        logic               finished_flag;
        logic               error_flag;
    } res_item_t;

    // Byte store access for one item
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;

endpackage

>>> src/bbsf_cfg.sv
// Register port holding the usable capacity
`timescale 1ns / 1ps

module bbsf_cfg
    import bbsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CAP_W-1:0]   capacity
);

    logic [CAP_W-1:0] cap_reg;
    logic             cap_hit;

    // word decode; byte offset bits ignored
    assign cap_hit = (paddr[PADDR_W-1:2] == REG_CAPACITY);

    // capacity register, written in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && cap_hit)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // read back
    assign prdata   = cap_hit ? PDATA_W'(cap_reg) : '0;
    assign pready   = 1'b1;
    assign capacity = cap_reg;

endmodule

>>> src/bbsf_store.sv
// Byte store: one write port, one registered read port with write bypass
`timescale 1ns / 1ps

module bbsf_store
    import bbsf_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write, and read the new head; a byte written this cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rdata_reg <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bbsf_ctrl.sv
// Pointer, count and flag update for one accepted command per cycle
`timescale 1ns / 1ps

module bbsf_ctrl
    import bbsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  cmd_item_t        item,
    input  logic [CAP_W-1:0] capacity,
    output mem_req_t         mem_req,
    output res_item_t        res_next
);

    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [TOTAL_W-1:0] pushed_reg, pushed_next;
    logic [TOTAL_W-1:0] popped_reg, popped_next;
    logic               closed_reg, closed_next;
    logic               error_reg, error_next;

    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   pop_n;
    logic [SUM_W-1:0]   rp_sum;
    logic [SUM_W-1:0]   rp_wrap;
    logic [PTR_W-1:0]   wp_inc;
    logic [TOTAL_W:0]   pop_total;
    logic               room;
    logic               push_ok;

    // capacity clamped to the store depth
    assign cap_eff = (CAP_CMP_W'(capacity) > CAP_CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                                : CNT_W'(capacity);
    assign room    = (fill_reg < cap_eff);

    // pop amount never exceeds the fill level
    assign pop_n   = (LEN_CMP_W'(item.pop_length) < LEN_CMP_W'(fill_reg))
                     ? CNT_W'(item.pop_length) : fill_reg;
    assign rp_sum  = SUM_W'(rp_reg) + SUM_W'(pop_n);
    assign rp_wrap = (rp_sum >= SUM_W'(DEPTH)) ? rp_sum - SUM_W'(DEPTH) : rp_sum;

    assign wp_inc  = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // saturating removed total
    assign pop_total = {1'b0, popped_reg} + (TOTAL_W + 1)'(pop_n);

    // next state for the command
    always_comb
    begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        pushed_next = pushed_reg;
        popped_next = popped_reg;
        closed_next = closed_reg;
        error_next  = error_reg;
        push_ok     = 1'b0;
        case (item.command)
            CMD_PUSH:
            begin
                if (room)
                begin
                    push_ok   = 1'b1;
                    wp_next   = wp_inc;
                    fill_next = fill_reg + 1'b1;
                    if (pushed_reg != '1)
                    begin
                        pushed_next = pushed_reg + 1'b1;
                    end
                end
            end
            CMD_POP:
            begin
                rp_next     = rp_wrap[PTR_W-1:0];
                fill_next   = fill_reg - pop_n;
                popped_next = pop_total[TOTAL_W] ? '1 : pop_total[TOTAL_W-1:0];
            end
            CMD_CLOSE:
            begin
                closed_next = 1'b1;
            end
            CMD_ERROR:
            begin
                error_next = 1'b1;
            end
            default:
            begin
                // status and unused codes change nothing
            end
        endcase
    end

    // state registers, loaded per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            pushed_reg <= '0;
            popped_reg <= '0;
            closed_reg <= 1'b0;
            error_reg  <= 1'b0;
        end
        else if (accept)
        begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            closed_reg <= closed_next;
            error_reg  <= error_next;
        end
    end

    // store access: write the pushed byte, fetch the new head
    always_comb
    begin
        mem_req.we    = accept && push_ok;
        mem_req.waddr = wp_reg;
        mem_req.wdata = item.data_byte;
        mem_req.re    = accept;
        mem_req.raddr = rp_next;
    end

    // result fields after the step; head byte comes from the store
    always_comb
    begin
        res_next.push_accepted  = push_ok;
        res_next.head_byte      = '0;
        res_next.head_valid     = (fill_next != '0);
        res_next.buffered_count = COUNT_W'(fill_next);
        res_next.free_space     = (cap_eff > fill_next) ? COUNT_W'(cap_eff - fill_next) : '0;
        res_next.pushed_sum     = pushed_next;
        res_next.total_popped   = popped_next;
        res_next.closed_flag    = closed_next;
        res_next.finished_flag  = closed_next && (fill_next == '0);
        res_next.error_flag     = error_next;
    end

endmodule

>>> src/bounded_byte_stream_fifo.sv
// Top level of the bounded byte FIFO: handshakes, result register, assertions
//
//  channel   signals                       width      direction
//  command   cmd_valid/cmd_ready/cmd_item  27 bits    in
//  result    res_valid/res_ready/res_item  103 bits   out
//  config    psel/penable/pwrite/paddr...  32 bits    in (write), out (read)
//
// One command is taken per cycle while cmd_ready is high; its result appears in
// the result register on the next cycle. The head byte is fetched from the single
// read port of the byte store in the same cycle as the pointer update.
// The command side stalls only while a result is held and res_ready is low.
// Reset empties the queue at once and sets the capacity to 4096; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_byte_stream_fifo
    import bbsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_item_t          cmd_item,
    output logic               res_valid,
    input  logic               res_ready,
    output res_item_t          res_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic              accept;
    logic [CAP_W-1:0]  capacity;
    mem_req_t          mem_req;
    res_item_t         res_next;
    res_item_t         res_reg;
    logic              res_valid_reg;
    logic [BYTE_W-1:0] head_rdata;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;

    bbsf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    bbsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (cmd_item),
        .capacity (capacity),
        .mem_req  (mem_req),
        .res_next (res_next)
    );

    bbsf_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (head_rdata)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // merge the fetched head byte; empty queue reads as zero
    always_comb
    begin
        res_item           = res_reg;
        res_item.head_byte = res_reg.head_valid ? head_rdata : '0;
    end

    assign res_valid = res_valid_reg;

    // every accepted item leaves a result behind
    `BBSF_ASSERT_NEXT(a_item_gives_result, accept, res_valid)
    // finished implies closed and nothing buffered
    `BBSF_ASSERT_NOW(a_finished_consistent, res_valid && res_item.finished_flag,
        res_item.closed_flag && !res_item.head_valid && (res_item.buffered_count == '0))
    // only a push can report a stored byte
    `BBSF_ASSERT_NEXT(a_push_only, accept && (cmd_item.command != CMD_PUSH),
        !res_item.push_accepted)

endmodule
